@@ rtl/radar_report_frame_parser_core_assert.svh @@
// Assertion macros used by the frame parser core.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef RADAR_REPORT_FRAME_PARSER_CORE_ASSERT_SVH
`define RADAR_REPORT_FRAME_PARSER_CORE_ASSERT_SVH
// Consequent must hold in the same cycle as the antecedent.
`define RRFP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame parser check failed");
// Consequent must hold in the cycle after the antecedent.
`define RRFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame parser check failed");
`endif

@@ rtl/rrfp_pkg.sv @@
// Package of the radar report frame parser: frame layout constants and pattern lookups.
// No dependencies; imported by the top level.
package rrfp_pkg;

  localparam int GATES       = 16;
  localparam int GATE_W      = 4;
  localparam int BODY_LEN    = 3 + 2 * GATES;
  localparam int HEAD_LEN    = 4;
  localparam int LEN_OVERHEAD = 6 + 4;
  localparam int FRAME_SIZE  = LEN_OVERHEAD + BODY_LEN;
  localparam int STORE_DEPTH = 45;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Byte positions inside a frame.
  localparam int LEN_POS     = 4;
  localparam int DETECT_POS  = 6;
  localparam int DIST_POS    = 7;
  localparam int ENERGY_POS  = 9;
  localparam int FOOT_POS    = 6 + BODY_LEN;

  localparam logic [7:0] HEAD0     = 8'hF4;
  localparam logic [7:0] HEAD1     = 8'hF3;
  localparam logic [7:0] HEAD2     = 8'hF2;
  localparam logic [7:0] HEAD3     = 8'hF1;
  localparam logic [7:0] FOOT0     = 8'hF8;
  localparam logic [7:0] FOOT1     = 8'hF7;
  localparam logic [7:0] FOOT2     = 8'hF6;
  localparam logic [7:0] FOOT3     = 8'hF5;
  localparam logic [7:0] DETECT_ON = 8'h01;

  function automatic logic [7:0] head_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = HEAD0;
      2'd1:    b = HEAD1;
      2'd2:    b = HEAD2;
      default: b = HEAD3;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] foot_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = FOOT0;
      2'd1:    b = FOOT1;
      2'd2:    b = FOOT2;
      default: b = FOOT3;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/rrfp_if.sv @@
// Valid/ready channel interfaces of the frame parser: received bytes in, gate results out.
// No dependencies.
interface rrfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rrfp_out_if;
  logic        valid;
  logic        ready;
  logic        presence;
  logic [15:0] target_range;
  logic [3:0]  gate_index;
  logic [15:0] gate_power;
  logic        last_gate;
  modport source (output valid, output presence, output target_range, output gate_index,
                  output gate_power, output last_gate, input ready);
  modport sink   (input valid, input presence, input target_range, input gate_index,
                  input gate_power, input last_gate, output ready);
endinterface

@@ rtl/rrfp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 45
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/radar_report_frame_parser_core.sv @@
// Radar report frame parser: hunts the frame header, stores the frame, emits one
// beat per range gate. Depends on rrfp_pkg, rrfp_if, rrfp_ram and the assertion header.
//
// Usage:
//   in_ch carries one received serial byte per beat. While the parser is collecting
//   a frame it takes one byte every cycle. out_ch carries one result beat per range
//   gate of a good frame: presence, distance, gate index, gate energy and a flag on
//   the final gate. Frames with a bad length or footer produce no beats.
//   The frame bytes go to a 45-byte store with one write and one read port. When the
//   last byte of a good frame is taken the parser stops accepting bytes and walks
//   the gates: for each gate it reads the low and then the high energy byte from
//   the store (ST_RD_LO, ST_RD_HI), captures the pair (ST_CAP) and holds the beat
//   on out_ch (ST_OUT). The next gate's reads start only once that beat is taken,
//   so a gate is done before the next begins. The store read port paces the walk.
//   Byte intake resumes in the cycle after the last gate beat is taken.
//   If the receiver stalls, the beat holds on out_ch and the parser waits.
//   Reset (synchronous, active low) returns the parser to header hunting with no
//   beat pending; the store is not cleared, since every read byte was written first.
module radar_report_frame_parser_core
  import rrfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  rrfp_in_if.sink           in_ch,
  rrfp_out_if.source        out_ch
);

  `include "radar_report_frame_parser_core_assert.svh"

  typedef enum logic [6:0] {
    ST_HUNT  = 7'b0000001,
    ST_LEN   = 7'b0000010,
    ST_BODY  = 7'b0000100,
    ST_RD_LO = 7'b0001000,
    ST_RD_HI = 7'b0010000,
    ST_CAP   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  // Control state.
  state_t              state_r, state_nxt;
  logic [1:0]          hdr_r, hdr_nxt;
  logic [ADDR_W-1:0]   pos_r, pos_nxt;
  logic [ADDR_W-1:0]   total_r, total_nxt;
  logic [GATE_W-1:0]   gate_r, gate_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Payload state.
  logic [7:0]          len_lo_r, len_lo_nxt;
  logic                detect_r, detect_nxt;
  logic [15:0]         dist_r, dist_nxt;
  logic                foot_bad_r, foot_bad_nxt;
  logic [7:0]          energy_lo_r, energy_lo_nxt;
  logic [15:0]         out_energy_r, out_energy_nxt;
  logic [GATE_W-1:0]   out_gate_r, out_gate_nxt;
  logic                out_last_r, out_last_nxt;

  // Store port signals.
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [7:0]          ram_rdata;

  logic                in_fire;
  logic [7:0]          in_byte;
  logic [ADDR_W-1:0]   pos_inc;
  logic [ADDR_W-1:0]   rd_base;
  logic [1:0]          foot_idx;
  logic [16:0]         frame_len;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_byte  = in_ch.rx_byte;
  assign pos_inc  = pos_r + ADDR_W'(1);
  // Each gate's energy is a little-endian pair starting at the energy area.
  assign rd_base  = ADDR_W'(ENERGY_POS) + ADDR_W'({gate_r, 1'b0});
  assign foot_idx = 2'(pos_r - ADDR_W'(FOOT_POS));
  // Header, length field and footer around the announced body length.
  assign frame_len = 17'(LEN_OVERHEAD) + {1'b0, in_byte, len_lo_r};

  assign in_ch.ready         = (state_r == ST_HUNT) || (state_r == ST_LEN) ||
                               (state_r == ST_BODY);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.presence     = detect_r;
  assign out_ch.target_range = dist_r;
  assign out_ch.gate_index   = out_gate_r;
  assign out_ch.gate_power   = out_energy_r;
  assign out_ch.last_gate    = out_last_r;

  rrfp_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    hdr_nxt        = hdr_r;
    pos_nxt        = pos_r;
    total_nxt      = total_r;
    gate_nxt       = gate_r;
    out_valid_nxt  = out_valid_r;
    len_lo_nxt     = len_lo_r;
    detect_nxt     = detect_r;
    dist_nxt       = dist_r;
    foot_bad_nxt   = foot_bad_r;
    energy_lo_nxt  = energy_lo_r;
    out_energy_nxt = out_energy_r;
    out_gate_nxt   = out_gate_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_re         = 1'b0;
    ram_raddr      = rd_base;

    case (state_r)
      ST_HUNT: begin
        if (in_fire) begin
          if (in_byte == head_byte(hdr_r)) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(hdr_r);
            if (hdr_r == 2'(HEAD_LEN - 1)) begin
              hdr_nxt      = 2'd0;
              pos_nxt      = ADDR_W'(HEAD_LEN);
              foot_bad_nxt = 1'b0;
              state_nxt    = ST_LEN;
            end else begin
              hdr_nxt = hdr_r + 2'd1;
            end
          end else if (in_byte == HEAD0) begin
            // A stray first header byte restarts the match at one.
            ram_we    = 1'b1;
            ram_waddr = '0;
            hdr_nxt   = 2'd1;
          end else begin
            hdr_nxt = 2'd0;
          end
        end
      end
      ST_LEN: begin
        if (in_fire) begin
          ram_we  = 1'b1;
          pos_nxt = pos_inc;
          if (pos_r == ADDR_W'(LEN_POS)) begin
            len_lo_nxt = in_byte;
          end else if (frame_len > 17'(FRAME_SIZE)) begin
            // Frame cannot fit in the store: drop it and hunt again.
            pos_nxt   = '0;
            total_nxt = '0;
            state_nxt = ST_HUNT;
          end else begin
            total_nxt = frame_len[ADDR_W-1:0];
            state_nxt = ST_BODY;
          end
        end
      end
      ST_BODY: begin
        if (in_fire) begin
          ram_we  = (pos_r < ADDR_W'(STORE_DEPTH));
          pos_nxt = pos_inc;
          if (pos_r == ADDR_W'(DETECT_POS)) begin
            detect_nxt = (in_byte == DETECT_ON);
          end
          if (pos_r == ADDR_W'(DIST_POS)) begin
            dist_nxt[7:0] = in_byte;
          end
          if (pos_r == ADDR_W'(DIST_POS + 1)) begin
            dist_nxt[15:8] = in_byte;
          end
          if (pos_r >= ADDR_W'(FOOT_POS) && in_byte != foot_byte(foot_idx)) begin
            foot_bad_nxt = 1'b1;
          end
          if (pos_inc >= total_r) begin
            pos_nxt   = '0;
            total_nxt = '0;
            // Only a full-length frame with the right footer is reported.
            if (total_r == ADDR_W'(FRAME_SIZE) && !foot_bad_nxt) begin
              gate_nxt  = '0;
              state_nxt = ST_RD_LO;
            end else begin
              state_nxt = ST_HUNT;
            end
          end
        end
      end
      ST_RD_LO: begin
        ram_re    = 1'b1;
        ram_raddr = rd_base;
        state_nxt = ST_RD_HI;
      end
      ST_RD_HI: begin
        ram_re        = 1'b1;
        ram_raddr     = rd_base + ADDR_W'(1);
        energy_lo_nxt = ram_rdata;
        state_nxt     = ST_CAP;
      end
      ST_CAP: begin
        out_energy_nxt = {ram_rdata, energy_lo_r};
        out_gate_nxt   = gate_r;
        out_last_nxt   = (gate_r == GATE_W'(GATES - 1));
        out_valid_nxt  = 1'b1;
        state_nxt      = ST_OUT;
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = ST_HUNT;
          end else begin
            gate_nxt  = gate_r + GATE_W'(1);
            state_nxt = ST_RD_LO;
          end
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HUNT;
      hdr_r       <= '0;
      pos_r       <= '0;
      total_r     <= '0;
      gate_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hdr_r       <= hdr_nxt;
      pos_r       <= pos_nxt;
      total_r     <= total_nxt;
      gate_r      <= gate_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_lo_r     <= len_lo_nxt;
    detect_r     <= detect_nxt;
    dist_r       <= dist_nxt;
    foot_bad_r   <= foot_bad_nxt;
    energy_lo_r  <= energy_lo_nxt;
    out_energy_r <= out_energy_nxt;
    out_gate_r   <= out_gate_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Byte intake and gate readout never overlap.
  `RRFP_ASSERT_SAME(a_ready_no_result, in_ch.ready, !out_ch.valid)
  // The final gate beat carries the highest gate number.
  `RRFP_ASSERT_SAME(a_last_index, out_valid_r && out_last_r, out_gate_r == GATE_W'(GATES - 1))
  // Taking the final gate beat hands control back to byte intake.
  `RRFP_ASSERT_NEXT(a_last_resumes, out_valid_r && out_ch.ready && out_last_r, in_ch.ready)
  // Any other taken gate beat starts the next gate's store reads.
  `RRFP_ASSERT_NEXT(a_gate_steps, out_valid_r && out_ch.ready && !out_last_r, state_r == ST_RD_LO)
  // The write position stays inside the store while the body is collected.
  `RRFP_ASSERT_SAME(a_pos_in_store, state_r == ST_BODY, pos_r < ADDR_W'(STORE_DEPTH))

endmodule
